// ===== rtl/gpti_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gpti_pkg
// Shared types and constants of the grid plane triangle index generator.
// ---------------------------------------------------------------------------
package gpti_pkg;

	localparam int unsigned CFG_W        = 9;   // width of a side register
	localparam int unsigned IDX_W        = 17;  // width of a vertex index
	localparam int unsigned DEF_MAX_SIDE = 256;
	localparam int unsigned QUEUE_DEPTH  = 2;
	localparam int unsigned CORNERS      = 6;   // indices per grid copy of one cell
	localparam int unsigned STEP_W       = $clog2(2 * CORNERS);

	localparam logic [CFG_W-1:0] X_SIZE_RESET    = CFG_W'(2);
	localparam logic [CFG_W-1:0] Z_SIZE_RESET    = CFG_W'(2);
	localparam logic             TWO_SIDED_RESET = 1'b0;

	typedef enum logic [1:0] {
		REG_X_SIZE    = 2'd0,
		REG_Z_SIZE    = 2'd1,
		REG_TWO_SIDED = 2'd2
	} cfg_reg_t;

	// One cell command: corner a, corner c, back copy offset and flags
	typedef struct packed {
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] c;
		logic [IDX_W-1:0] off;
		logic             two_sided;
		logic             last_mesh;
	} cell_cmd_t;

	typedef struct packed {
		logic can_push;
		logic has_data;
	} q_status_t;

endpackage

// ===== rtl/gpti_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gpti_queue
// Short register queue of cell commands between the front and the back.
// ---------------------------------------------------------------------------
module gpti_queue import gpti_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cell_cmd_t push_cmd,
	input  logic      pop,
	output cell_cmd_t head_cmd,
	output q_status_t status
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	cell_cmd_t        entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign head_cmd        = entry_q[rd_ptr_q];
	assign status.can_push = (count_q != CNT_W'(QUEUE_DEPTH));
	assign status.has_data = (count_q != '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> status.can_push)
		else $error("push into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> status.has_data)
		else $error("pop from an empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

// ===== rtl/gpti_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gpti_front
// Accepts requests, walks the cell position and issues one command per cell.
// ---------------------------------------------------------------------------
module gpti_front import gpti_pkg::*; #(
	parameter int unsigned MAX_SIDE = DEF_MAX_SIDE
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CFG_W-1:0] x_size,
	input  logic [CFG_W-1:0] z_size,
	input  logic             two_sided,
	input  logic             accept,
	input  logic             restart,
	output logic             push,
	output cell_cmd_t        push_cmd
);

	localparam int unsigned CW    = $clog2(MAX_SIDE);
	localparam int unsigned CMP_W = ((CW > CFG_W) ? CW : CFG_W) + 1;
	localparam int unsigned CLAMP = (MAX_SIDE < (1 << CFG_W)) ? MAX_SIDE : (1 << CFG_W) - 1;

	logic [CW-1:0]    cell_x_q;
	logic [CW-1:0]    cell_z_q;
	logic [IDX_W-1:0] row_base_q;
	logic             mesh_done_q;

	logic [CFG_W-1:0] xs, zs;
	logic [CMP_W-1:0] xs_m1, zs_m1, xs_m2, zs_m2;
	logic [CMP_W-1:0] cx_e, cz_e, cz_inc_e, cx_inc_e;
	logic [CW-1:0]    cx, cz;
	logic [IDX_W-1:0] rb;
	logic             done, no_cells, out_of_grid, emit, row_end;
	logic [2*CFG_W-1:0] area;

	assign xs = (x_size > CFG_W'(CLAMP)) ? CFG_W'(CLAMP) : x_size;
	assign zs = (z_size > CFG_W'(CLAMP)) ? CFG_W'(CLAMP) : z_size;

	// restart takes effect before this request is classified
	assign cx   = restart ? '0 : cell_x_q;
	assign cz   = restart ? '0 : cell_z_q;
	assign rb   = restart ? '0 : row_base_q;
	assign done = restart ? 1'b0 : mesh_done_q;

	assign xs_m1    = CMP_W'(xs) - CMP_W'(1);
	assign zs_m1    = CMP_W'(zs) - CMP_W'(1);
	assign xs_m2    = CMP_W'(xs) - CMP_W'(2);
	assign zs_m2    = CMP_W'(zs) - CMP_W'(2);
	assign cx_e     = CMP_W'(cx);
	assign cz_e     = CMP_W'(cz);
	assign cx_inc_e = cx_e + CMP_W'(1);
	assign cz_inc_e = cz_e + CMP_W'(1);

	assign no_cells    = (xs < CFG_W'(2)) || (zs < CFG_W'(2));
	assign out_of_grid = (cx_e >= xs_m1) || (cz_e >= zs_m1);
	assign emit        = !done && !no_cells && !out_of_grid;
	assign row_end     = (cz_inc_e >= zs_m1);

	assign area = CFG_W'(xs) * CFG_W'(zs);

	assign push               = accept && emit;
	assign push_cmd.a         = rb + IDX_W'(cz);
	assign push_cmd.c         = rb + IDX_W'(zs) + IDX_W'(cz);
	assign push_cmd.off       = IDX_W'(area);
	assign push_cmd.two_sided = two_sided;
	assign push_cmd.last_mesh = (cx_e == xs_m2) && (cz_e == zs_m2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_x_q    <= '0;
			cell_z_q    <= '0;
			row_base_q  <= '0;
			mesh_done_q <= 1'b0;
		end else if (accept) begin
			cell_x_q    <= cx;
			cell_z_q    <= cz;
			row_base_q  <= rb;
			mesh_done_q <= done;
			if (!done && !no_cells) begin
				if (out_of_grid) begin
					mesh_done_q <= 1'b1;
				end else if (row_end) begin
					// advance to the next row of cells
					cell_z_q    <= '0;
					cell_x_q    <= cx + CW'(1);
					row_base_q  <= rb + IDX_W'(zs);
					mesh_done_q <= (cx_inc_e >= xs_m1);
				end else begin
					cell_z_q <= cz + CW'(1);
				end
			end
		end
	end

	a_emit_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cx_e < xs_m1) && (cz_e < zs_m1) && !no_cells)
		else $error("command issued for a cell outside the grid");
	a_done_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(mesh_done_q && !(accept && restart)) |=> mesh_done_q)
		else $error("mesh done cleared without restart");
	a_no_push_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!mesh_done_q || restart))
		else $error("command issued after the mesh closed");

endmodule

// ===== rtl/gpti_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gpti_back
// Expands one cell command into its corner indices, one per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
module gpti_back import gpti_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_cmd_t        head_cmd,
	input  q_status_t        q_status,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [IDX_W-1:0] vertex_index,
	output logic             last_of_cell,
	output logic             last_of_mesh
);

	localparam int unsigned CRN_W = $clog2(CORNERS);

	// corner pattern: front (a,b,c) (c,b,d), back (a,c,b) (c,d,b); bit k = corner k
	localparam logic [CORNERS-1:0] FRONT_USE_C = 6'b101100;
	localparam logic [CORNERS-1:0] FRONT_INC   = 6'b110010;
	localparam logic [CORNERS-1:0] BACK_USE_C  = 6'b011010;
	localparam logic [CORNERS-1:0] BACK_INC    = 6'b110100;

	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [IDX_W-1:0]  vertex_index_q;
	logic              last_of_cell_q;
	logic              last_of_mesh_q;

	logic              load, advance, back_side, use_c, inc, last_step;
	logic [STEP_W-1:0] last_idx;
	logic [CRN_W-1:0]  corner;
	logic [IDX_W-1:0]  index_nxt;

	assign load    = !out_valid_q || !out_stall;
	assign advance = q_status.has_data && load;

	assign last_idx  = head_cmd.two_sided ? STEP_W'(2 * CORNERS - 1) : STEP_W'(CORNERS - 1);
	assign last_step = (step_q == last_idx);
	assign back_side = (step_q >= STEP_W'(CORNERS));
	assign corner    = back_side ? CRN_W'(step_q - STEP_W'(CORNERS)) : CRN_W'(step_q);
	assign use_c     = back_side ? BACK_USE_C[corner] : FRONT_USE_C[corner];
	assign inc       = back_side ? BACK_INC[corner] : FRONT_INC[corner];

	assign index_nxt = (use_c ? head_cmd.c : head_cmd.a) + IDX_W'(inc)
		+ (back_side ? head_cmd.off : '0);

	assign pop = advance && last_step;

	always_ff @(posedge clk) begin
		if (advance) begin
			vertex_index_q <= index_nxt;
			last_of_cell_q <= last_step;
			last_of_mesh_q <= last_step && head_cmd.last_mesh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= q_status.has_data;
			end
			if (advance) begin
				step_q <= last_step ? '0 : step_q + STEP_W'(1);
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign vertex_index = vertex_index_q;
	assign last_of_cell = last_of_cell_q;
	assign last_of_mesh = last_of_mesh_q;

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_W'(2 * CORNERS - 1))
		else $error("corner step out of range");
	a_mid_cell_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != '0) |-> q_status.has_data)
		else $error("cell command lost mid-expansion");
	a_mesh_implies_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_of_mesh) |-> last_of_cell)
		else $error("mesh end flagged off a cell end");

endmodule

// ===== rtl/grid_plane_triangle_index_gen_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_plane_triangle_index_gen_unit
// Emits triangle corner indices of a regular vertex grid, one cell a request.
// ---------------------------------------------------------------------------
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_stall  | restart
// out      | out_valid / out_stall| vertex_index, last_of_cell, last_of_mesh
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A cell gives 6 indices, or 12 when two-sided, one per cycle from the
// expansion sequencer while the output is not stalled.
// A request is taken whenever the two-entry command queue has room; the first
// index of a cell passes through the queue entry and then the output register.
// Reset clears the cell position, queue and output valid flag; no sweep follows.
// A request that causes no indices is absorbed in its accept cycle.
// ---------------------------------------------------------------------------
module grid_plane_triangle_index_gen_unit import gpti_pkg::*; #(
	parameter int unsigned MAX_SIDE = DEF_MAX_SIDE
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             restart,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [IDX_W-1:0] vertex_index,
	output logic             last_of_cell,
	output logic             last_of_mesh,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0] x_size_q;
	logic [CFG_W-1:0] z_size_q;
	logic             two_sided_q;

	logic      accept, push, pop;
	cell_cmd_t push_cmd, head_cmd;
	q_status_t q_status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_size_q    <= X_SIZE_RESET;
			z_size_q    <= Z_SIZE_RESET;
			two_sided_q <= TWO_SIDED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_X_SIZE:    x_size_q    <= cfg_data;
				REG_Z_SIZE:    z_size_q    <= cfg_data;
				REG_TWO_SIDED: two_sided_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_stall = !q_status.can_push;
	assign accept   = in_valid && !in_stall;

	gpti_front #(
		.MAX_SIDE (MAX_SIDE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.x_size    (x_size_q),
		.z_size    (z_size_q),
		.two_sided (two_sided_q),
		.accept    (accept),
		.restart   (restart),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	gpti_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.status   (q_status)
	);

	gpti_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_cmd     (head_cmd),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.vertex_index (vertex_index),
		.last_of_cell (last_of_cell),
		.last_of_mesh (last_of_mesh)
	);

endmodule

// ===== tb/gpti_index_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gpti_index_checker
// Tracks the request, index and config channels of the triangle index
// generator, predicts the corner indices of every accepted cell request and
// compares them field by field, in order, with the indices the block emits.
// ---------------------------------------------------------------------------
module gpti_index_checker import gpti_pkg::*; #(
	parameter int unsigned MAX_SIDE = DEF_MAX_SIDE
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic             restart,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [IDX_W-1:0] vertex_index,
	input  logic             last_of_cell,
	input  logic             last_of_mesh,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output int               fail_count,
	output int               pending,
	output int               cells_requested,
	output int               corners_seen,
	output int               meshes_closed
);

	typedef struct packed {
		logic [IDX_W-1:0] vidx;
		logic             cell_end;
		logic             mesh_end;
	} corner_t;

	corner_t pending_corners [$];

	// Shadow of the config registers and of the cell walk
	logic [CFG_W-1:0] side_x;
	logic [CFG_W-1:0] side_z;
	logic             back_on;
	logic [7:0]       cur_x;
	logic [7:0]       cur_z;
	logic [15:0]      row_start;
	logic             grid_done;

	initial begin
		fail_count      = 0;
		pending         = 0;
		cells_requested = 0;
		corners_seen    = 0;
		meshes_closed   = 0;
	end

	function automatic int unsigned clamp_side(input logic [CFG_W-1:0] v);
		return (v > MAX_SIDE) ? MAX_SIDE : int'(v);
	endfunction

	task automatic predict_cell_corners(input logic rst);
		int unsigned xs;
		int unsigned zs;
		int unsigned a;
		int unsigned b;
		int unsigned c;
		int unsigned d;
		int unsigned back_off;
		int unsigned pts [12];
		int          n;
		logic        final_cell;
		xs = clamp_side(side_x);
		zs = clamp_side(side_z);
		if (rst) begin
			cur_x     = '0;
			cur_z     = '0;
			row_start = '0;
			grid_done = 1'b0;
		end
		if (grid_done || xs < 2 || zs < 2)
			return;
		// config shrank under the current cell: close the mesh silently
		if (cur_x >= xs - 1 || cur_z >= zs - 1) begin
			grid_done = 1'b1;
			return;
		end
		a = row_start + cur_z;
		b = a + 1;
		c = row_start + zs + cur_z;
		d = c + 1;
		pts[0] = a; pts[1] = b; pts[2] = c;
		pts[3] = c; pts[4] = b; pts[5] = d;
		n = 6;
		if (back_on) begin
			back_off = xs * zs;
			pts[6] = back_off + a; pts[7]  = back_off + c; pts[8]  = back_off + b;
			pts[9] = back_off + c; pts[10] = back_off + d; pts[11] = back_off + b;
			n = 12;
		end
		final_cell = (cur_x == xs - 2) && (cur_z == zs - 2);
		for (int k = 0; k < n; k++)
			pending_corners.insert(pending_corners.size(),
				corner_t'{IDX_W'(pts[k]), k == n - 1, final_cell && (k == n - 1)});
		// advance; row_start keeps the z size in force at each row step
		if (cur_z + 1 >= zs - 1) begin
			cur_z     = '0;
			cur_x     = cur_x + 8'd1;
			row_start = row_start + 16'(zs);
			if (cur_x >= xs - 1)
				grid_done = 1'b1;
		end else begin
			cur_z = cur_z + 8'd1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		corner_t want;
		if (!arst_n) begin
			side_x    = X_SIZE_RESET;
			side_z    = Z_SIZE_RESET;
			back_on   = TWO_SIDED_RESET;
			cur_x     = '0;
			cur_z     = '0;
			row_start = '0;
			grid_done = 1'b0;
			pending_corners.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_X_SIZE:    side_x  = cfg_data;
					REG_Z_SIZE:    side_z  = cfg_data;
					REG_TWO_SIDED: back_on = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				predict_cell_corners(restart);
				cells_requested++;
			end
			if (out_valid && !out_stall) begin
				corners_seen++;
				if (last_of_mesh === 1'b1)
					meshes_closed++;
				if (pending_corners.size() == 0) begin
					$error("unexpected index transaction: vertex_index %0d", vertex_index);
					fail_count++;
				end else begin
					want = pending_corners.pop_front();
					if (vertex_index !== want.vidx) begin
						$error("vertex_index: expected %0d, got %0d", want.vidx, vertex_index);
						fail_count++;
					end
					if (last_of_cell !== want.cell_end) begin
						$error("last_of_cell: expected %0b, got %0b", want.cell_end, last_of_cell);
						fail_count++;
					end
					if (last_of_mesh !== want.mesh_end) begin
						$error("last_of_mesh: expected %0b, got %0b", want.mesh_end, last_of_mesh);
						fail_count++;
					end
				end
			end
		end
		pending = pending_corners.size();
	end

endmodule

// ===== tb/tb_grid_plane_triangle_index_gen_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_grid_plane_triangle_index_gen_unit
// Drives cell requests and config writes into the triangle index generator:
// directed grids (default, two-sided, empty, clamped, resized mid-mesh), then
// random grids under three idle/stall mixes. The checker scores every index.
// ---------------------------------------------------------------------------
module tb_grid_plane_triangle_index_gen_unit import gpti_pkg::*;;

	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 8;
	localparam int QUIET_LIMIT   = 1000;
	localparam int PHASE_CELLS   = 30;

	logic             clk;
	logic             arst_n       = 1'b0;
	logic             in_valid     = 1'b0;
	logic             in_stall;
	logic             restart      = 1'b0;
	logic             out_valid;
	logic             out_stall    = 1'b0;
	logic [IDX_W-1:0] vertex_index;
	logic             last_of_cell;
	logic             last_of_mesh;
	logic             cfg_valid    = 1'b0;
	logic             cfg_ready;
	logic [1:0]       cfg_index    = REG_X_SIZE;
	logic [CFG_W-1:0] cfg_data     = '0;

	int fail_count;
	int pending;
	int cells_requested;
	int corners_seen;
	int meshes_closed;
	int cfg_writes    = 0;
	int quiet_cycles  = 0;
	int send_idle_pct = 24;
	int recv_idle_pct = 64;

	grid_plane_triangle_index_gen_unit DUT (.*);

	gpti_index_checker u_checker (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

	// Abort when no transaction moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_cell_req(input logic rst);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			restart  <= 1'($urandom_range(0, 1));
			@(negedge clk);
		end
		in_valid <= 1'b1;
		restart  <= rst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t which, input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_writes++;
		@(negedge clk);
	endtask

	// Drop the request and let every predicted index drain
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_grid(input logic [CFG_W-1:0] xs, input logic [CFG_W-1:0] zs,
			input logic two);
		settle();
		write_reg(REG_X_SIZE, xs);
		write_reg(REG_Z_SIZE, zs);
		write_reg(REG_TWO_SIDED, CFG_W'(two));
	endtask

	// Mostly small grids, now and then empty or oversized ones
	function automatic logic [CFG_W-1:0] pick_side();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return CFG_W'($urandom_range(0, 1));
		if (roll < 16)
			return CFG_W'($urandom_range(256, 511));
		return CFG_W'($urandom_range(2, 8));
	endfunction

	initial begin
		int run_len;
		int phase_cells;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default 2x2 grid: one cell, then nothing until restart
		send_cell_req(1'b0);
		send_cell_req(1'b0);
		send_cell_req(1'b1);

		// two-sided 3x4: six cells, one request past the end
		set_grid(9'd3, 9'd4, 1'b1);
		send_cell_req(1'b1);
		repeat (6) send_cell_req(1'b0);

		// empty grids
		set_grid(9'd1, 9'd4, 1'b0);
		send_cell_req(1'b1);
		set_grid(9'd0, 9'd0, 1'b1);
		send_cell_req(1'b0);

		// resize mid-mesh: first grow z and go on, then shrink under the cell
		set_grid(9'd4, 9'd4, 1'b0);
		send_cell_req(1'b1);
		repeat (2) send_cell_req(1'b0);
		settle();
		write_reg(REG_Z_SIZE, 9'd6);
		send_cell_req(1'b0);
		settle();
		write_reg(REG_Z_SIZE, 9'd2);
		send_cell_req(1'b0);

		// oversized sides clamp to the maximum
		set_grid(9'd511, 9'd256, 1'b1);
		send_cell_req(1'b1);
		repeat (2) send_cell_req(1'b0);
		settle();
		write_reg(REG_Z_SIZE, 9'd300);
		send_cell_req(1'b0);
		set_grid(9'd256, 9'd2, 1'b0);
		send_cell_req(1'b1);
		repeat (2) send_cell_req(1'b0);

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin send_idle_pct = 24; recv_idle_pct = 64; end
				1: begin send_idle_pct = 64; recv_idle_pct = 24; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			phase_cells = 0;
			while (phase_cells < PHASE_CELLS) begin
				settle();
				if ($urandom_range(0, 99) < 70)
					write_reg(REG_X_SIZE, pick_side());
				if ($urandom_range(0, 99) < 70)
					write_reg(REG_Z_SIZE, pick_side());
				if ($urandom_range(0, 99) < 60)
					write_reg(REG_TWO_SIDED, CFG_W'($urandom_range(0, 1)));
				run_len = $urandom_range(4, 14);
				for (int k = 0; k < run_len; k++) begin
					if (k == 0)
						send_cell_req($urandom_range(0, 99) < 75);
					else
						send_cell_req($urandom_range(0, 99) < 6);
					phase_cells++;
				end
			end
		end

		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Covered %0d cell requests and %0d register writes, %0d indices checked.",
			cells_requested, cfg_writes, corners_seen);
		$display("Grids: default, one- and two-sided, empty, clamped, resized mid-mesh; "
			, "%0d mesh ends seen.", meshes_closed);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
